FILE: sv/mpsa_pkg.sv
// shared constants and types of the multi-pool slot allocator
package mpsa_pkg;

  // pool geometry
  localparam int POOL_DEPTH = 64;
  localparam int POOL_COUNT = 4;

  // request and result field widths
  localparam int POOL_W   = 2;
  localparam int SLOT_W   = 6;
  localparam int IN_USE_W = 7;

  // internal widths that follow from the geometry
  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int PIDX_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

  // free-slot search runs over groups of eight bits
  localparam int GRP_SIZE  = 8;
  localparam int LOW_W     = $clog2(GRP_SIZE);
  localparam int GRP_COUNT = (POOL_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_W     = GRP_COUNT * GRP_SIZE;
  localparam int GIDX_W    = $clog2(PAD_W);

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // capture the incoming request
    logic scan;    // register the per-group free-slot summary
    logic commit;  // update pool state and load the result register
  } ctrl_cmd_t;

endpackage

FILE: sv/mpsa_ctrl.sv
// sequencing controller of the multi-pool slot allocator
module mpsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mpsa_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       commit;
  logic       accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == ST_UPD) && out_free;
  // a new request can enter in the same cycle that the previous one commits
  assign in_stall_o = !((state_q == ST_IDLE) || commit);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (commit) state_d = accept ? ST_SCAN : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.accept  = accept;
  assign cmd_o.scan    = (state_q == ST_SCAN);
  assign cmd_o.commit  = commit;

`ifndef SYNTH
  a_accept_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_scan_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |=> state_q == ST_UPD)
    else $error("scan not followed by update");

  a_commit_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("committed request left no result");
`endif

endmodule

FILE: sv/mpsa_datapath.sv
// pool bitmaps, counts, free-slot search and result register
module mpsa_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mpsa_pkg::ctrl_cmd_t             cmd_i,
  input  logic                            req_type_i,
  input  logic [mpsa_pkg::POOL_W-1:0]     pool_i,
  input  logic [mpsa_pkg::SLOT_W-1:0]     slot_in_i,
  output logic                            ok_o,
  output logic [mpsa_pkg::SLOT_W-1:0]     slot_out_o,
  output logic [mpsa_pkg::IN_USE_W-1:0]   in_use_o
);

  // pool state
  logic [mpsa_pkg::POOL_DEPTH-1:0] map_q [mpsa_pkg::POOL_COUNT];
  logic [mpsa_pkg::CNT_W-1:0]      cnt_q [mpsa_pkg::POOL_COUNT];

  // captured request
  logic                          req_type_q;
  logic [mpsa_pkg::POOL_W-1:0]   pool_q;
  logic [mpsa_pkg::SLOT_W-1:0]   slot_q;

  // per-group search summary
  logic [mpsa_pkg::GRP_COUNT-1:0] grp_any_d, grp_any_q;
  logic [mpsa_pkg::LOW_W-1:0]     grp_low_d [mpsa_pkg::GRP_COUNT];
  logic [mpsa_pkg::LOW_W-1:0]     grp_low_q [mpsa_pkg::GRP_COUNT];

  // result register
  logic                          ok_q, ok_d;
  logic [mpsa_pkg::SLOT_W-1:0]   slot_out_q, slot_out_d;
  logic [mpsa_pkg::IN_USE_W-1:0] in_use_q, in_use_d;

  logic                            pool_ok;
  logic [mpsa_pkg::PIDX_W-1:0]     pool_idx;
  logic [mpsa_pkg::POOL_DEPTH-1:0] map_sel;
  logic [mpsa_pkg::CNT_W-1:0]      cnt_sel;
  logic [mpsa_pkg::PAD_W-1:0]      free_pad;
  logic                            found;
  logic [mpsa_pkg::GIDX_W-1:0]     grant_pad;
  logic [mpsa_pkg::IDX_W-1:0]      grant_idx;
  logic                            slot_ok;
  logic [mpsa_pkg::IDX_W-1:0]      slot_idx;
  logic                            free_hit;
  logic                            upd_en;
  logic [mpsa_pkg::POOL_DEPTH-1:0] map_new;
  logic [mpsa_pkg::CNT_W-1:0]      cnt_new;

  assign pool_ok  = int'(pool_q) < mpsa_pkg::POOL_COUNT;
  assign pool_idx = mpsa_pkg::PIDX_W'(pool_q);
  assign map_sel  = map_q[pool_idx];
  assign cnt_sel  = cnt_q[pool_idx];
  assign slot_ok  = int'(slot_q) < mpsa_pkg::POOL_DEPTH;
  assign slot_idx = mpsa_pkg::IDX_W'(slot_q);
  assign free_hit = slot_ok && map_sel[slot_idx];

  // first stage: lowest free bit inside each group, padding counts as used
  always_comb begin
    free_pad = '0;
    free_pad[mpsa_pkg::POOL_DEPTH-1:0] = ~map_sel;
    for (int g = 0; g < mpsa_pkg::GRP_COUNT; g++) begin
      grp_any_d[g] = |free_pad[g*mpsa_pkg::GRP_SIZE +: mpsa_pkg::GRP_SIZE];
      grp_low_d[g] = '0;
      for (int k = mpsa_pkg::GRP_SIZE - 1; k >= 0; k--) begin
        if (free_pad[g*mpsa_pkg::GRP_SIZE + k]) grp_low_d[g] = mpsa_pkg::LOW_W'(k);
      end
    end
  end

  // second stage: lowest group that has a free bit
  always_comb begin
    found     = 1'b0;
    grant_pad = '0;
    for (int g = mpsa_pkg::GRP_COUNT - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found     = 1'b1;
        grant_pad = mpsa_pkg::GIDX_W'(g * mpsa_pkg::GRP_SIZE + int'(grp_low_q[g]));
      end
    end
  end

  assign grant_idx = mpsa_pkg::IDX_W'(grant_pad);

  always_comb begin
    map_new    = map_sel;
    cnt_new    = cnt_sel;
    upd_en     = 1'b0;
    ok_d       = 1'b0;
    slot_out_d = '0;
    in_use_d   = '0;
    if (pool_ok) begin
      if (req_type_q == mpsa_pkg::REQ_ALLOC) begin
        if (found) begin
          map_new[grant_idx] = 1'b1;
          cnt_new            = cnt_sel + 1'b1;
          upd_en             = 1'b1;
          ok_d               = 1'b1;
          slot_out_d         = mpsa_pkg::SLOT_W'(grant_idx);
        end
      end else begin
        slot_out_d = slot_q;
        if (free_hit) begin
          map_new[slot_idx] = 1'b0;
          if (cnt_sel != '0) cnt_new = cnt_sel - 1'b1;
          upd_en = 1'b1;
          ok_d   = 1'b1;
        end
      end
      in_use_d = mpsa_pkg::IN_USE_W'(cnt_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < mpsa_pkg::POOL_COUNT; p++) begin
        map_q[p] <= '0;
        cnt_q[p] <= '0;
      end
    end else if (cmd_i.commit && upd_en) begin
      map_q[pool_idx] <= map_new;
      cnt_q[pool_idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_type_q <= req_type_i;
      pool_q     <= pool_i;
      slot_q     <= slot_in_i;
    end
    if (cmd_i.scan) begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < mpsa_pkg::GRP_COUNT; g++) grp_low_q[g] <= grp_low_d[g];
    end
    if (cmd_i.commit) begin
      ok_q       <= ok_d;
      slot_out_q <= slot_out_d;
      in_use_q   <= in_use_d;
    end
  end

  assign ok_o       = ok_q;
  assign slot_out_o = slot_out_q;
  assign in_use_o   = in_use_q;

`ifndef SYNTH
  for (genvar p = 0; p < mpsa_pkg::POOL_COUNT; p++) begin : g_chk
    a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
      int'(cnt_q[p]) == $countones(map_q[p]))
      else $error("pool count does not match its bitmap");
  end

  a_grant_was_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && pool_ok && req_type_q == mpsa_pkg::REQ_ALLOC && found
    |-> !map_sel[grant_idx])
    else $error("granted slot already in use");
`endif

endmodule

FILE: sv/multi_pool_slot_allocator_unit.sv
// top level of the multi-pool slot allocator
// Keeps four pools of 64 slots, each with a usage bitmap and a count of the
// slots in use. An allocate request (req_type 0) grants the lowest free slot
// of the named pool and returns it with the new count; on a full pool ok is 0,
// slot_out is 0 and in_use is the unchanged count. A free request (req_type 1)
// releases slot_in; if that slot is not in use nothing changes and ok is 0.
// Every request gives exactly one result, in order. Each request is first
// captured; next the free-slot summary of eight-bit groups is registered
// from the pool bitmap; last the lowest group is picked and bitmap, count
// and the result register are updated. A new request is taken in the cycle
// the previous one commits, and not before; a stalled result holds the
// block at the commit step. Reset clears all bitmaps and counts at once, no
// clearing pass.
module multi_pool_slot_allocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [mpsa_pkg::POOL_W-1:0]   pool_i,
  input  logic [mpsa_pkg::SLOT_W-1:0]   slot_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [mpsa_pkg::SLOT_W-1:0]   slot_out_o,
  output logic [mpsa_pkg::IN_USE_W-1:0] in_use_o
);

  // commands from sequencer to datapath
  mpsa_pkg::ctrl_cmd_t cmd;

  // sequencer: accept, scan, commit
  mpsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // pool state, slot search and result register
  mpsa_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_type_i (req_type_i),
    .pool_i     (pool_i),
    .slot_in_i  (slot_in_i),
    .ok_o       (ok_o),
    .slot_out_o (slot_out_o),
    .in_use_o   (in_use_o)
  );

endmodule

FILE: tb/sv/tb_multi_pool_slot_allocator_unit.sv
// testbench for the multi-pool slot allocator: directed table, fill and drain runs, random mix
`timescale 1ns / 100ps

module tb_multi_pool_slot_allocator_unit;

  // run length and the watchdog
  localparam int RAND_ITEMS   = 650;
  localparam int LIMIT_CYCLES = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 8;

  // one result of the block
  typedef struct packed {
    logic                          ok;
    logic [mpsa_pkg::SLOT_W-1:0]   slot;
    logic [mpsa_pkg::IN_USE_W-1:0] in_use;
  } slot_result_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    logic                        rt;
    logic [mpsa_pkg::POOL_W-1:0] pool;
    logic [mpsa_pkg::SLOT_W-1:0] slot;
    logic                        typed;
    slot_result_t                want;
  } stim_row_t;

  localparam int DIR_ROWS = 18;

  // walk from reset over all four pools; slot_in 63 also rides on an allocate,
  // where it must be ignored
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{mpsa_pkg::REQ_ALLOC, 2'd0, 6'd0,  1'b1, '{1'b1, 6'd0,  7'd1}},  // first grant after reset
    '{mpsa_pkg::REQ_ALLOC, 2'd0, 6'd0,  1'b1, '{1'b1, 6'd1,  7'd2}},
    '{mpsa_pkg::REQ_ALLOC, 2'd0, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_FREE,  2'd0, 6'd1,  1'b0, '{1'b0, 6'd0,  7'd0}},  // hole in the middle
    '{mpsa_pkg::REQ_ALLOC, 2'd0, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},  // refills the hole
    '{mpsa_pkg::REQ_FREE,  2'd0, 6'd63, 1'b1, '{1'b0, 6'd63, 7'd3}},  // top slot not in use
    '{mpsa_pkg::REQ_FREE,  2'd3, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},  // free in an empty pool
    '{mpsa_pkg::REQ_ALLOC, 2'd3, 6'd0,  1'b1, '{1'b1, 6'd0,  7'd1}},
    '{mpsa_pkg::REQ_FREE,  2'd3, 6'd0,  1'b1, '{1'b1, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_FREE,  2'd3, 6'd0,  1'b1, '{1'b0, 6'd0,  7'd0}},  // double free
    '{mpsa_pkg::REQ_ALLOC, 2'd1, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_ALLOC, 2'd2, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_FREE,  2'd2, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_FREE,  2'd1, 6'd0,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_ALLOC, 2'd3, 6'd63, 1'b1, '{1'b1, 6'd0,  7'd1}},  // slot_in ignored
    '{mpsa_pkg::REQ_FREE,  2'd0, 6'd0,  1'b1, '{1'b1, 6'd0,  7'd2}},
    '{mpsa_pkg::REQ_FREE,  2'd0, 6'd2,  1'b0, '{1'b0, 6'd0,  7'd0}},
    '{mpsa_pkg::REQ_FREE,  2'd0, 6'd1,  1'b0, '{1'b0, 6'd0,  7'd0}}
  };

  // clock, reset and the ports of the block
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic                          req_type_i  = mpsa_pkg::REQ_ALLOC;
  logic [mpsa_pkg::POOL_W-1:0]   pool_i      = '0;
  logic [mpsa_pkg::SLOT_W-1:0]   slot_in_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          ok_o;
  logic [mpsa_pkg::SLOT_W-1:0]   slot_out_o;
  logic [mpsa_pkg::IN_USE_W-1:0] in_use_o;

  // shadow copy of the pool state, advanced once per accepted request
  logic [mpsa_pkg::POOL_DEPTH-1:0] shadow_map [mpsa_pkg::POOL_COUNT];
  logic [mpsa_pkg::IN_USE_W-1:0]   shadow_count [mpsa_pkg::POOL_COUNT];

  // results owed by the block, oldest first
  slot_result_t pending_results [$];

  // idling percentages of the two sides, set per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // bookkeeping
  int cycle_count    = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int alloc_count    = 0;
  int free_count     = 0;
  int full_refusals  = 0;
  int idle_frees     = 0;

  multi_pool_slot_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .pool_i      (pool_i),
    .slot_in_i   (slot_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ok_o        (ok_o),
    .slot_out_o  (slot_out_o),
    .in_use_o    (in_use_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // allocate takes the lowest free slot, free releases a used slot; a full pool
  // or a slot that is not in use leaves the state alone and reports ok = 0
  function automatic slot_result_t allocate_or_free(input logic rt,
                                                    input logic [mpsa_pkg::POOL_W-1:0] p,
                                                    input logic [mpsa_pkg::SLOT_W-1:0] s);
    slot_result_t r;
    logic         found;
    int           i;
    r     = '0;
    found = 1'b0;
    if (int'(p) >= mpsa_pkg::POOL_COUNT) begin
      return r;
    end
    if (rt == mpsa_pkg::REQ_ALLOC) begin
      r.in_use = shadow_count[p];
      for (i = 0; i < mpsa_pkg::POOL_DEPTH; i++) begin
        if (!found && !shadow_map[p][i]) begin
          found              = 1'b1;
          shadow_map[p][i]   = 1'b1;
          shadow_count[p]    = shadow_count[p] + 1'b1;
          r.ok               = 1'b1;
          r.slot             = mpsa_pkg::SLOT_W'(i);
          r.in_use           = shadow_count[p];
        end
      end
    end else begin
      r.slot = s;
      if (int'(s) < mpsa_pkg::POOL_DEPTH && shadow_map[p][s]) begin
        shadow_map[p][s] = 1'b0;
        if (shadow_count[p] != 0) shadow_count[p] = shadow_count[p] - 1'b1;
        r.ok = 1'b1;
      end
      r.in_use = shadow_count[p];
    end
    return r;
  endfunction

  // a random slot that is currently held in pool p, or any slot if none is
  function automatic logic [mpsa_pkg::SLOT_W-1:0] pick_used_slot(
      input logic [mpsa_pkg::POOL_W-1:0] p);
    int                          held;
    int                          k;
    int                          i;
    logic [mpsa_pkg::SLOT_W-1:0] pick;
    held = $countones(shadow_map[p]);
    pick = mpsa_pkg::SLOT_W'($urandom_range(0, mpsa_pkg::POOL_DEPTH - 1));
    if (held != 0) begin
      k = $urandom_range(0, held - 1);
      for (i = 0; i < mpsa_pkg::POOL_DEPTH; i++) begin
        if (shadow_map[p][i]) begin
          if (k == 0) pick = mpsa_pkg::SLOT_W'(i);
          k--;
        end
      end
    end
    return pick;
  endfunction

  // present one request, hold it until taken, then book its expected result;
  // called at a rising edge, returns at the edge that accepts the request
  task automatic issue_request(input logic rt, input logic [mpsa_pkg::POOL_W-1:0] p,
                               input logic [mpsa_pkg::SLOT_W-1:0] s, input logic typed,
                               input slot_result_t want);
    slot_result_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    pool_i     <= p;
    slot_in_i  <= s;
    // sample at the falling edge so the handshake is read between updates
    do @(negedge clk_i); while (in_stall_o);
    r = allocate_or_free(rt, p, s);
    if (typed) r = want;
    pending_results.push_back(r);
    requests_sent++;
    if (rt == mpsa_pkg::REQ_ALLOC) begin
      alloc_count++;
      if (!r.ok) full_refusals++;
    end else begin
      free_count++;
      if (!r.ok) idle_frees++;
    end
    @(posedge clk_i);
  endtask

  // receiver side: random stall decided at every rising edge
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // result checker, sampled mid-cycle so the values are the ones at the next edge
  always @(negedge clk_i) begin
    slot_result_t got;
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{ok: ok_o, slot: slot_out_o, in_use: in_use_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result ok=%0d slot=%0d in_use=%0d, no request pending",
                   got.ok, got.slot, got.in_use);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.slot !== want.slot || got.in_use !== want.in_use) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d: expected ok=%0d slot=%0d in_use=%0d, %s%0d %s%0d %s%0d",
                     results_seen, want.ok, want.slot, want.in_use,
                     "got ok=", got.ok, "slot=", got.slot, "in_use=", got.in_use);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic                        rt;
    logic [mpsa_pkg::POOL_W-1:0] p;
    logic [mpsa_pkg::SLOT_W-1:0] s;
    int                          kind;
    int                          phase;
    int                          row;
    for (row = 0; row < mpsa_pkg::POOL_COUNT; row++) begin
      shadow_map[row]   = '0;
      shadow_count[row] = '0;
    end

    // reset held low from the start, released on an edge
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, sender light and receiver heavy
    tx_idle_pct = 9;
    rx_idle_pct = 54;
    for (row = 0; row < DIR_ROWS; row++) begin
      issue_request(DIRECTED[row].rt, DIRECTED[row].pool, DIRECTED[row].slot,
                    DIRECTED[row].typed, DIRECTED[row].want);
    end

    // random part in episodes: fill a pool past full, drain one in random
    // order, or a short mixed burst; the idling pattern moves through three
    // phases as the request count grows
    while (requests_sent < DIR_ROWS + RAND_ITEMS) begin
      phase = (requests_sent - DIR_ROWS) * 3 / RAND_ITEMS;
      case (phase)
        0: begin
          tx_idle_pct = 9;
          rx_idle_pct = 54;
        end
        1: begin
          tx_idle_pct = 54;
          rx_idle_pct = 9;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      kind = $urandom_range(0, 9);
      p    = mpsa_pkg::POOL_W'($urandom_range(0, mpsa_pkg::POOL_COUNT - 1));
      if (kind < 2) begin
        // fill to all 64 slots, then a few refused allocates
        while (shadow_count[p] < mpsa_pkg::IN_USE_W'(mpsa_pkg::POOL_DEPTH)) begin
          issue_request(mpsa_pkg::REQ_ALLOC, p, mpsa_pkg::SLOT_W'($urandom), 1'b0, '0);
        end
        repeat ($urandom_range(1, 3)) begin
          issue_request(mpsa_pkg::REQ_ALLOC, p, mpsa_pkg::SLOT_W'($urandom), 1'b0, '0);
        end
      end else if (kind < 4) begin
        // drain mostly held slots, with the odd stray free mixed in
        repeat ($urandom_range(1, mpsa_pkg::POOL_DEPTH)) begin
          if ($urandom_range(0, 6) == 0) s = mpsa_pkg::SLOT_W'($urandom);
          else s = pick_used_slot(p);
          issue_request(mpsa_pkg::REQ_FREE, p, s, 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 16)) begin
          rt = $urandom_range(0, 1) ? mpsa_pkg::REQ_FREE : mpsa_pkg::REQ_ALLOC;
          p  = mpsa_pkg::POOL_W'($urandom_range(0, mpsa_pkg::POOL_COUNT - 1));
          if (rt == mpsa_pkg::REQ_FREE && $urandom_range(0, 3) != 0) s = pick_used_slot(p);
          else s = mpsa_pkg::SLOT_W'($urandom);
          issue_request(rt, p, s, 1'b0, '0);
        end
      end
    end
    in_valid_i <= 1'b0;

    // let every owed result come out, then a short quiet tail
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d requests (%0d allocates, %0d frees) over %0d cycles, %0d checked",
             requests_sent, alloc_count, free_count, cycle_count, results_seen);
    $display("saw %0d allocates on a full pool and %0d frees of slots not in use",
             full_refusals, idle_frees);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mpsa_pkg.sv
sv/mpsa_ctrl.sv
sv/mpsa_datapath.sv
sv/multi_pool_slot_allocator_unit.sv
tb/sv/tb_multi_pool_slot_allocator_unit.sv
